@@ hw/rtl/ntcs_pkg.sv @@
// ----------------------------------------------------------------------------
// ntcs_pkg: shared types and constants for the cube texel sampler
// Opcodes, status codes, register indexes, the config bundle and the word
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ntcs_pkg;

	localparam int STORE_BYTES = 65536;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int BANKS       = 4;
	localparam int ROWS        = STORE_BYTES / BANKS;
	localparam int ROW_W       = ADDR_W - 2;
	localparam int MAX_EXTENT  = 256;
	localparam int EXT_W       = 9;
	localparam int TEX_W       = 9;
	localparam int QUO_W       = 8;
	localparam int NUM_W       = 25;
	localparam int DEN_W       = 17;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_FACE  = 2'd1;
	localparam logic [1:0] OP_2D    = 2'd2;
	localparam logic [1:0] OP_CUBE  = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NOT_READY  = 3'd1;
	localparam logic [2:0] ST_WRONG_TYPE = 3'd2;
	localparam logic [2:0] ST_BAD_FACE   = 3'd3;
	localparam logic [2:0] ST_OOB        = 3'd4;
	localparam logic [2:0] ST_ZERO_DIR   = 3'd5;

	localparam logic [2:0] REG_EXTENT_X      = 3'd0;
	localparam logic [2:0] REG_EXTENT_Y      = 3'd1;
	localparam logic [2:0] REG_EXTENT_Z      = 3'd2;
	localparam logic [2:0] REG_CHANNEL_COUNT = 3'd3;
	localparam logic [2:0] REG_TEXTURE_KIND  = 3'd4;
	localparam logic [2:0] REG_LOADED_BYTES  = 3'd5;
	localparam logic [2:0] REG_READY         = 3'd6;

	typedef struct packed {
		logic [EXT_W-1:0] extent_x;
		logic [EXT_W-1:0] extent_y;
		logic [EXT_W-1:0] extent_z;
		logic [2:0]       channel_count;
		logic             texture_kind;
		logic [16:0]      loaded_bytes;
		logic             ready;
	} cfg_t;

	typedef struct packed {
		logic              is_write;
		logic              is_cube;
		logic [2:0]        err;
		logic [2:0]        face;
		logic [TEX_W-1:0]  tx;
		logic [TEX_W-1:0]  ty;
		logic [TEX_W-1:0]  tz;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wbyte;
	} work_t;

	// extent limited to 1..MAX_EXTENT
	function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] e);
		logic [EXT_W-1:0] r;
		if (e == '0)
			r = EXT_W'(1);
		else if (e > EXT_W'(MAX_EXTENT))
			r = EXT_W'(MAX_EXTENT);
		else
			r = e;
		return r;
	endfunction

	function automatic logic [QUO_W-1:0] ext_m1(input logic [EXT_W-1:0] e);
		logic [EXT_W-1:0] c;
		c = clamp_ext(e) - EXT_W'(1);
		return c[QUO_W-1:0];
	endfunction

endpackage

@@ hw/rtl/ntcs_div.sv @@
// ----------------------------------------------------------------------------
// ntcs_div: pipelined restoring divider
// One quotient bit per stage, eight stages; quotient must fit in 8 bits.
// ----------------------------------------------------------------------------
module ntcs_div (
	input  logic                        clk,
	input  logic [ntcs_pkg::NUM_W-1:0]  num,
	input  logic [ntcs_pkg::DEN_W-1:0]  den,
	output logic [ntcs_pkg::QUO_W-1:0]  quo
);

	logic [ntcs_pkg::NUM_W-1:0] rem_s [ntcs_pkg::QUO_W];
	logic [ntcs_pkg::DEN_W-1:0] den_s [ntcs_pkg::QUO_W];
	logic [ntcs_pkg::QUO_W-1:0] quo_s [ntcs_pkg::QUO_W];

	for (genvar k = 0; k < ntcs_pkg::QUO_W; k++) begin : g_stage
		logic [ntcs_pkg::NUM_W-1:0] rin;
		logic [ntcs_pkg::DEN_W-1:0] din;
		logic [ntcs_pkg::QUO_W-1:0] qin;
		logic [ntcs_pkg::NUM_W-1:0] dsh;
		logic                       ge;

		if (k == 0) begin : g_first
			assign rin = num;
			assign din = den;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[k-1];
			assign din = den_s[k-1];
			assign qin = quo_s[k-1];
		end

		assign dsh = ntcs_pkg::NUM_W'(din) << (ntcs_pkg::QUO_W - 1 - k);
		assign ge  = (rin >= dsh);

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? (rin - dsh) : rin;
			den_s[k] <= din;
			quo_s[k] <= {qin[ntcs_pkg::QUO_W-2:0], ge};
		end
	end

	assign quo = quo_s[ntcs_pkg::QUO_W-1];

endmodule

@@ hw/rtl/ntcs_front.sv @@
// ----------------------------------------------------------------------------
// ntcs_front: command classification and texel coordinate generation
// Early status checks, cube face pick, Q1.16 rounding and cube division.
// ----------------------------------------------------------------------------
module ntcs_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ntcs_pkg::cfg_t        cfg,
	input  logic                  take,
	input  logic [1:0]            opcode,
	input  logic [15:0]           write_address,
	input  logic [7:0]            write_byte,
	input  logic [16:0]           coord_u,
	input  logic [16:0]           coord_v,
	input  logic [16:0]           coord_w,
	input  logic [2:0]            face_select,
	input  logic signed [15:0]    dir_x,
	input  logic signed [15:0]    dir_y,
	input  logic signed [15:0]    dir_z,
	output logic                  push,
	output ntcs_pkg::work_t       push_word
);

	localparam int DL = ntcs_pkg::QUO_W;

	logic [ntcs_pkg::QUO_W-1:0] exm1, eym1, ezm1;
	assign exm1 = ntcs_pkg::ext_m1(cfg.extent_x);
	assign eym1 = ntcs_pkg::ext_m1(cfg.extent_y);
	assign ezm1 = ntcs_pkg::ext_m1(cfg.extent_z);

	// ---- classification and cube axis pick ----
	logic signed [16:0] x, y, z, cu, cv;
	logic [16:0]        ax, ay, az, m;
	logic [2:0]         cface;
	logic [17:0]        su, sv;
	logic [25:0]        pu, pv, pw;
	ntcs_pkg::work_t    w_in;

	assign x  = {dir_x[15], dir_x};
	assign y  = {dir_y[15], dir_y};
	assign z  = {dir_z[15], dir_z};
	assign ax = x[16] ? 17'(-x) : 17'(x);
	assign ay = y[16] ? 17'(-y) : 17'(y);
	assign az = z[16] ? 17'(-z) : 17'(z);

	always_comb begin
		if (az >= ax && az >= ay) begin
			m = az;
			if (z[16]) begin
				cface = 3'd5; cu = -x; cv = -y;
			end else begin
				cface = 3'd4; cu = x;  cv = -y;
			end
		end else if (ay >= ax) begin
			m = ay;
			if (y[16]) begin
				cface = 3'd3; cu = x; cv = -z;
			end else begin
				cface = 3'd2; cu = x; cv = z;
			end
		end else begin
			m = ax;
			if (x[16]) begin
				cface = 3'd1; cu = z;  cv = -y;
			end else begin
				cface = 3'd0; cu = -z; cv = -y;
			end
		end
	end

	// c + m lies in 0..2m
	assign su = {cu[16], cu} + {1'b0, m};
	assign sv = {cv[16], cv} + {1'b0, m};

	// round to nearest texel: (q*(ext-1) + half) >> 16
	assign pu = 26'(coord_u) * 26'(exm1) + 26'd32768;
	assign pv = 26'(coord_v) * 26'(eym1) + 26'd32768;
	assign pw = 26'(coord_w) * 26'(ezm1) + 26'd32768;

	always_comb begin
		w_in          = '0;
		w_in.is_write = (opcode == ntcs_pkg::OP_WRITE);
		w_in.is_cube  = (opcode == ntcs_pkg::OP_CUBE);
		w_in.waddr    = write_address;
		w_in.wbyte    = write_byte;
		w_in.tx       = pu[24:16];
		w_in.ty       = pv[24:16];
		w_in.tz       = (opcode == ntcs_pkg::OP_FACE) ? pw[24:16] : '0;
		case (opcode)
			ntcs_pkg::OP_FACE: w_in.face = face_select;
			ntcs_pkg::OP_CUBE: w_in.face = cface;
			default:           w_in.face = '0;
		endcase
		if (opcode == ntcs_pkg::OP_WRITE)
			w_in.err = ntcs_pkg::ST_OK;
		else if ((opcode == ntcs_pkg::OP_2D && cfg.texture_kind) ||
			(opcode == ntcs_pkg::OP_CUBE && !cfg.texture_kind))
			w_in.err = ntcs_pkg::ST_WRONG_TYPE;
		else if (!cfg.ready)
			w_in.err = ntcs_pkg::ST_NOT_READY;
		else if (opcode == ntcs_pkg::OP_CUBE && m == '0)
			w_in.err = ntcs_pkg::ST_ZERO_DIR;
		else
			w_in.err = ntcs_pkg::ST_OK;
	end

	// ---- stage 1 ----
	logic            v_s1;
	ntcs_pkg::work_t w_s1;
	logic [16:0]     nu_s1, nv_s1, m_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		w_s1  <= w_in;
		nu_s1 <= su[16:0];
		nv_s1 <= sv[16:0];
		m_s1  <= m;
	end

	// ---- stage 2: cube numerator and divisor ----
	logic                       v_s2;
	ntcs_pkg::work_t            w_s2;
	logic [ntcs_pkg::NUM_W-1:0] numu_s2, numv_s2;
	logic [ntcs_pkg::DEN_W-1:0] den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		w_s2    <= w_s1;
		numu_s2 <= ntcs_pkg::NUM_W'(nu_s1) * ntcs_pkg::NUM_W'(exm1) + ntcs_pkg::NUM_W'(m_s1);
		numv_s2 <= ntcs_pkg::NUM_W'(nv_s1) * ntcs_pkg::NUM_W'(eym1) + ntcs_pkg::NUM_W'(m_s1);
		den_s2  <= {m_s1[15:0], 1'b0};
	end

	// ---- divider stages, side data runs alongside ----
	logic [ntcs_pkg::QUO_W-1:0] qu, qv;

	ntcs_div u_div_u (.clk(clk), .num(numu_s2), .den(den_s2), .quo(qu));
	ntcs_div u_div_v (.clk(clk), .num(numv_s2), .den(den_s2), .quo(qv));

	logic            v_d [DL];
	ntcs_pkg::work_t w_d [DL];

	for (genvar k = 0; k < DL; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k] <= 1'b0;
			end else begin
				v_d[k] <= (k == 0) ? v_s2 : v_d[k == 0 ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			w_d[k] <= (k == 0) ? w_s2 : w_d[k == 0 ? 0 : k-1];
		end
	end

	always_comb begin
		push_word = w_d[DL-1];
		if (w_d[DL-1].is_cube) begin
			push_word.tx = ntcs_pkg::TEX_W'(qu);
			push_word.ty = ntcs_pkg::TEX_W'(qv);
		end
	end

	assign push = v_d[DL-1];

endmodule

@@ hw/rtl/ntcs_queue.sv @@
// ----------------------------------------------------------------------------
// ntcs_queue: short word queue between front end and back end
// Register based, head visible combinationally.
// ----------------------------------------------------------------------------
module ntcs_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  ntcs_pkg::work_t             push_word,
	input  logic                        pop,
	output ntcs_pkg::work_t             head,
	output logic                        empty,
	output logic                        full
);

	ntcs_pkg::work_t             mem_q [ntcs_pkg::QDEPTH];
	logic [ntcs_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [ntcs_pkg::QCNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == ntcs_pkg::QCNT_W'(ntcs_pkg::QDEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_word;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue underflow");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count mismatch");

endmodule

@@ hw/rtl/ntcs_back.sv @@
// ----------------------------------------------------------------------------
// ntcs_back: address build, bounds check, banked texel store and formatting
// Four byte banks give one whole texel per cycle.
// ----------------------------------------------------------------------------
module ntcs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ntcs_pkg::cfg_t    cfg,
	input  logic              avail,
	input  ntcs_pkg::work_t   head,
	output logic              pop,
	output logic              done,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic [7:0]        alpha,
	output logic [2:0]        status
);

	logic [ntcs_pkg::EXT_W-1:0] ex, ey, ez;
	assign ex = ntcs_pkg::clamp_ext(cfg.extent_x);
	assign ey = ntcs_pkg::clamp_ext(cfg.extent_y);
	assign ez = ntcs_pkg::clamp_ext(cfg.extent_z);

	assign pop = avail;

	// ---- s1: face/depth term and config checks ----
	logic            v_s1;
	ntcs_pkg::work_t w_s1;
	logic [11:0]     fz_s1;
	logic [2:0]      err_in;
	logic [2:0]      faces;
	ntcs_pkg::work_t w_chk;

	assign faces = cfg.texture_kind ? 3'd6 : 3'd1;

	always_comb begin
		if (head.is_write || head.err != ntcs_pkg::ST_OK)
			err_in = head.err;
		else if (head.face >= faces)
			err_in = ntcs_pkg::ST_BAD_FACE;
		else if (cfg.loaded_bytes == '0)
			err_in = ntcs_pkg::ST_NOT_READY;
		else if (cfg.channel_count == 3'd0 || cfg.channel_count > 3'd4)
			err_in = ntcs_pkg::ST_WRONG_TYPE;
		else
			err_in = ntcs_pkg::ST_OK;
	end

	always_comb begin
		w_chk     = head;
		w_chk.err = err_in;
	end

	// ---- s2..s4: address products ----
	logic            v_s2, v_s3, v_s4;
	ntcs_pkg::work_t w_s2, w_s3, w_s4;
	logic [20:0]     t1_s2;
	logic [29:0]     t2_s3;
	logic [11:0]     txcc_s3;
	logic [33:0]     addr_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= avail;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		w_s1     <= w_chk;
		fz_s1    <= 12'(head.face) * 12'(ez) + 12'(head.tz);
		w_s2     <= w_s1;
		t1_s2    <= 21'(fz_s1) * 21'(ey) + 21'(w_s1.ty);
		w_s3     <= w_s2;
		t2_s3    <= 30'(t1_s2) * 30'(ex);
		txcc_s3  <= 12'(w_s2.tx) * 12'(cfg.channel_count);
		w_s4     <= w_s3;
		addr_s4  <= 34'(t2_s3) * 34'(cfg.channel_count) + 34'(txcc_s3);
	end

	// ---- s5: bounds check and store access ----
	logic [16:0]                limit;
	logic                       oob;
	logic [ntcs_pkg::ADDR_W-1:0] a16;

	assign limit = (cfg.loaded_bytes < 17'(ntcs_pkg::STORE_BYTES)) ?
		cfg.loaded_bytes : 17'(ntcs_pkg::STORE_BYTES);
	// whole texel must sit below the limit
	assign oob = (35'(addr_s4) + 35'(cfg.channel_count)) > 35'(limit);
	assign a16 = w_s4.is_write ? w_s4.waddr : addr_s4[ntcs_pkg::ADDR_W-1:0];

	logic       v_s5;
	logic       wr_s5;
	logic [2:0] err_s5;
	logic [2:0] cc_s5;
	logic [1:0] lo_s5;
	logic [7:0] rd_s5 [ntcs_pkg::BANKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		wr_s5 <= w_s4.is_write;
		cc_s5 <= cfg.channel_count;
		lo_s5 <= a16[1:0];
		if (!w_s4.is_write && w_s4.err == ntcs_pkg::ST_OK && oob)
			err_s5 <= ntcs_pkg::ST_OOB;
		else
			err_s5 <= w_s4.err;
	end

	for (genvar b = 0; b < ntcs_pkg::BANKS; b++) begin : g_bank
		logic [7:0]                  mem [ntcs_pkg::ROWS];
		logic [1:0]                  off;
		logic [ntcs_pkg::ADDR_W-1:0] byte_a;
		logic                        we;

		assign off    = 2'(b) - a16[1:0];
		assign byte_a = a16 + ntcs_pkg::ADDR_W'(off);
		assign we     = v_s4 && w_s4.is_write && (a16[1:0] == 2'(b));

		always_ff @(posedge clk) begin
			if (we)
				mem[a16[ntcs_pkg::ADDR_W-1:2]] <= w_s4.wbyte;
			rd_s5[b] <= mem[byte_a[ntcs_pkg::ADDR_W-1:2]];
		end
	end

	// ---- s6: channel layout into result registers ----
	logic [7:0] d0, d1, d2, d3;
	assign d0 = rd_s5[lo_s5];
	assign d1 = rd_s5[2'(lo_s5 + 2'd1)];
	assign d2 = rd_s5[2'(lo_s5 + 2'd2)];
	assign d3 = rd_s5[2'(lo_s5 + 2'd3)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		status <= err_s5;
		if (wr_s5 || err_s5 != ntcs_pkg::ST_OK) begin
			red <= '0; green <= '0; blue <= '0; alpha <= '0;
		end else begin
			case (cc_s5)
				3'd1: begin
					red <= d0; green <= d0; blue <= d0; alpha <= d0;
				end
				3'd2: begin
					red <= d0; green <= d1; blue <= 8'd0; alpha <= 8'd255;
				end
				3'd3: begin
					red <= d0; green <= d1; blue <= d2; alpha <= 8'd255;
				end
				default: begin
					red <= d0; green <= d1; blue <= d2; alpha <= d3;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/nearest_texel_cube_sampler_top.sv @@
// ----------------------------------------------------------------------------
// nearest_texel_cube_sampler_top: byte texel store with nearest sampler
// Takes write and sample commands, returns one result word per command.
//
// Usage:
//   - Command channel: a word is taken at a clock edge with start high and
//     busy low. opcode picks write byte, sample with face, sample 2D or
//     sample cube.
//   - Result channel: done is high for exactly one cycle per command with
//     red/green/blue/alpha/status; the receiver cannot hold it off.
//   - Config: cfg_we writes register cfg_index with cfg_wdata at once; only
//     write while no command is in flight.
//   - Every opcode runs through the same pipe stages. Throughput: one
//     command per clock, set by the pipelined 8-stage cube divider and
//     the four-bank store with one port per bank.
//   - Writes land in the store in command order, in the same pipe stage
//     that samples read, so a sample sees every earlier write.
//   - Reset clears the config to defaults and empties the pipe; store
//     contents stay undefined until written. busy only rises if the
//     internal queue fills, which cannot happen since results never stall.
// ----------------------------------------------------------------------------
module nearest_texel_cube_sampler_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          opcode,
	input  logic [15:0]         write_address,
	input  logic [7:0]          write_byte,
	input  logic [16:0]         coord_u,
	input  logic [16:0]         coord_v,
	input  logic [16:0]         coord_w,
	input  logic [2:0]          face_select,
	input  logic signed [15:0]  dir_x,
	input  logic signed [15:0]  dir_y,
	input  logic signed [15:0]  dir_z,
	output logic                done,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue,
	output logic [7:0]          alpha,
	output logic [2:0]          status,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [16:0]         cfg_wdata
);

	// config register file
	ntcs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.extent_x      <= 9'd1;
			cfg_q.extent_y      <= 9'd1;
			cfg_q.extent_z      <= 9'd1;
			cfg_q.channel_count <= 3'd4;
			cfg_q.texture_kind  <= 1'b0;
			cfg_q.loaded_bytes  <= '0;
			cfg_q.ready         <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ntcs_pkg::REG_EXTENT_X:      cfg_q.extent_x      <= cfg_wdata[8:0];
				ntcs_pkg::REG_EXTENT_Y:      cfg_q.extent_y      <= cfg_wdata[8:0];
				ntcs_pkg::REG_EXTENT_Z:      cfg_q.extent_z      <= cfg_wdata[8:0];
				ntcs_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_wdata[2:0];
				ntcs_pkg::REG_TEXTURE_KIND:  cfg_q.texture_kind  <= cfg_wdata[0];
				ntcs_pkg::REG_LOADED_BYTES:  cfg_q.loaded_bytes  <= cfg_wdata;
				ntcs_pkg::REG_READY:         cfg_q.ready         <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// command accept
	logic take;
	logic q_full, q_empty;
	assign busy = q_full;
	assign take = start && !busy;

	// front end: classify, round coordinates, cube divide
	logic            push;
	ntcs_pkg::work_t push_word;

	ntcs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.take          (take),
		.opcode        (opcode),
		.write_address (write_address),
		.write_byte    (write_byte),
		.coord_u       (coord_u),
		.coord_v       (coord_v),
		.coord_w       (coord_w),
		.face_select   (face_select),
		.dir_x         (dir_x),
		.dir_y         (dir_y),
		.dir_z         (dir_z),
		.push          (push),
		.push_word     (push_word)
	);

	// decoupling queue
	logic            pop;
	ntcs_pkg::work_t head;

	ntcs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// back end: address, bounds, store, result word
	ntcs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.avail  (!q_empty),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.alpha  (alpha),
		.status (status)
	);

endmodule

@@ tb/nearest_texel_cube_sampler_top_test.sv @@
// ----------------------------------------------------------------------------
// nearest_texel_cube_sampler_top_test: self-checking bench for the sampler
// Drives write and sample commands with random gaps. A built-in predictor
// computes each result word in command order, and a monitor compares every
// done word with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module nearest_texel_cube_sampler_top_test;
	import ntcs_pkg::*;

	typedef struct {
		logic [1:0]         op;
		logic [15:0]        waddr;
		logic [7:0]         wbyte;
		logic [16:0]        u;
		logic [16:0]        v;
		logic [16:0]        w;
		logic [2:0]         face;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [15:0] dz;
	} cmd_t;

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic [2:0] st;
	} texel_word_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         opcode;
	logic [15:0]        write_address;
	logic [7:0]         write_byte;
	logic [16:0]        coord_u;
	logic [16:0]        coord_v;
	logic [16:0]        coord_w;
	logic [2:0]         face_select;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	logic               done;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic [7:0]         alpha;
	logic [2:0]         status;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [16:0]        cfg_wdata;

	// mirror of the config registers and of the texel store
	logic [8:0]  m_ext_x, m_ext_y, m_ext_z;
	logic [2:0]  m_chan;
	logic        m_kind;
	logic [16:0] m_loaded;
	logic        m_ready;
	logic [7:0]  texel_mirror [0:65535];
	bit          texel_written [0:65535];

	texel_word_t pending_words [$];
	int          mismatches;
	int          quiet_cycles;

	nearest_texel_cube_sampler_top u_top (.*);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------
	function automatic longint clamp_extent(input logic [8:0] e);
		if (e == 0)
			return 1;
		if (e > 256)
			return 256;
		return e;
	endfunction

	function automatic longint q16_texel(input longint q, input longint ext);
		return (q * (ext - 1) + 32768) >> 16;
	endfunction

	function automatic longint cube_texel(input longint c, input longint m, input longint ext);
		return ((c + m) * (ext - 1) + m) / (2 * m);
	endfunction

	// Result word for one sample; reads says whether the store is read, and
	// at which byte address.
	function automatic texel_word_t predict_sample(input cmd_t c, output bit reads,
			output longint addr);
		texel_word_t res;
		longint ex, ey, ez, cc, face, tx, ty, tz, lim, x, y, z, ax, ay, az, m, cu, cv;
		ex = clamp_extent(m_ext_x);
		ey = clamp_extent(m_ext_y);
		ez = clamp_extent(m_ext_z);
		cc = m_chan;
		res = '{0, 0, 0, 0, ST_OK};
		reads = 0;
		addr = 0;
		if ((c.op == OP_2D && m_kind) || (c.op == OP_CUBE && !m_kind)) begin
			res.st = ST_WRONG_TYPE;
			return res;
		end
		if (!m_ready) begin
			res.st = ST_NOT_READY;
			return res;
		end
		tz = 0;
		if (c.op == OP_CUBE) begin
			x = c.dx;
			y = c.dy;
			z = c.dz;
			ax = x < 0 ? -x : x;
			ay = y < 0 ? -y : y;
			az = z < 0 ? -z : z;
			// z wins ties, then y, then x
			if (az >= ax && az >= ay) begin
				m = az;
				if (z < 0) begin face = 5; cu = -x; cv = -y; end
				else begin face = 4; cu = x; cv = -y; end
			end else if (ay >= ax) begin
				m = ay;
				if (y < 0) begin face = 3; cu = x; cv = -z; end
				else begin face = 2; cu = x; cv = z; end
			end else begin
				m = ax;
				if (x < 0) begin face = 1; cu = z; cv = -y; end
				else begin face = 0; cu = -z; cv = -y; end
			end
			if (m == 0) begin
				res.st = ST_ZERO_DIR;
				return res;
			end
			tx = cube_texel(cu, m, ex);
			ty = cube_texel(cv, m, ey);
		end else begin
			face = (c.op == OP_FACE) ? c.face : 0;
			tx = q16_texel(c.u, ex);
			ty = q16_texel(c.v, ey);
			tz = (c.op == OP_2D) ? 0 : q16_texel(c.w, ez);
		end
		if (face >= (m_kind ? 6 : 1)) begin
			res.st = ST_BAD_FACE;
			return res;
		end
		if (m_loaded == 0) begin
			res.st = ST_NOT_READY;
			return res;
		end
		if (cc < 1 || cc > 4) begin
			res.st = ST_WRONG_TYPE;
			return res;
		end
		lim = m_loaded < 65536 ? m_loaded : 65536;
		addr = ((face * ez + tz) * ey + ty) * ex * cc + tx * cc;
		if (addr >= lim || lim - addr < cc) begin
			res.st = ST_OOB;
			return res;
		end
		reads = 1;
		res.r = texel_mirror[addr];
		res.g = cc >= 2 ? texel_mirror[addr + 1] : res.r;
		res.b = cc >= 3 ? texel_mirror[addr + 2] : (cc == 2 ? 8'd0 : res.r);
		res.a = cc == 4 ? texel_mirror[addr + 3] : (cc == 1 ? res.r : 8'd255);
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// driving
	// ------------------------------------------------------------------------
	task automatic push_word(input cmd_t c);
		@(negedge clk);
		start = 1;
		opcode = c.op;
		write_address = c.waddr;
		write_byte = c.wbyte;
		coord_u = c.u;
		coord_v = c.v;
		coord_w = c.w;
		face_select = c.face;
		dir_x = c.dx;
		dir_y = c.dy;
		dir_z = c.dz;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start = 0;
		end
	endtask

	task automatic store_byte(input logic [15:0] a, input logic [7:0] d);
		cmd_t c;
		c = '{OP_WRITE, a, d, 0, 0, 0, 0, 0, 0, 0};
		push_word(c);
		texel_mirror[a] = d;
		texel_written[a] = 1;
		pending_words.push_back('{0, 0, 0, 0, ST_OK});
	endtask

	// Sends one command; a sample that would read bytes never written gets
	// those bytes stored first.
	task automatic send_cmd(input cmd_t c);
		texel_word_t res;
		bit reads;
		longint addr;
		if (c.op == OP_WRITE) begin
			store_byte(c.waddr, c.wbyte);
			return;
		end
		res = predict_sample(c, reads, addr);
		if (reads)
			for (int k = 0; k < m_chan; k++)
				if (!texel_written[addr + k])
					store_byte(16'(addr + k), 8'($urandom));
		res = predict_sample(c, reads, addr);
		push_word(c);
		pending_words.push_back(res);
	endtask

	task automatic wait_drained();
		idle_cycles(1);
		while (pending_words.size() != 0)
			@(negedge clk);
		idle_cycles(20);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_wdata = val;
		case (idx)
			REG_EXTENT_X: m_ext_x = val[8:0];
			REG_EXTENT_Y: m_ext_y = val[8:0];
			REG_EXTENT_Z: m_ext_z = val[8:0];
			REG_CHANNEL_COUNT: m_chan = val[2:0];
			REG_TEXTURE_KIND: m_kind = val[0];
			REG_LOADED_BYTES: m_loaded = val;
			REG_READY: m_ready = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic set_texture(input int ex, input int ey, input int ez, input int cc,
			input int kind, input int loaded, input int rdy);
		wait_drained();
		write_reg(REG_EXTENT_X, 17'(ex));
		write_reg(REG_EXTENT_Y, 17'(ey));
		write_reg(REG_EXTENT_Z, 17'(ez));
		write_reg(REG_CHANNEL_COUNT, 17'(cc));
		write_reg(REG_TEXTURE_KIND, 17'(kind));
		write_reg(REG_LOADED_BYTES, 17'(loaded));
		write_reg(REG_READY, 17'(rdy));
	endtask

	function automatic cmd_t face_cmd(input logic [1:0] op, input int u, input int v,
			input int w, input int f);
		return '{op, 0, 0, 17'(u), 17'(v), 17'(w), 3'(f), 0, 0, 0};
	endfunction

	function automatic cmd_t dir_cmd(input int x, input int y, input int z);
		return '{OP_CUBE, 0, 0, 0, 0, 0, 0, 16'(x), 16'(y), 16'(z)};
	endfunction

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------
	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		texel_word_t want;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				report("unexpected word", status, -1);
			end else begin
				want = pending_words.pop_front();
				if (red !== want.r) report("red", red, want.r);
				if (green !== want.g) report("green", green, want.g);
				if (blue !== want.b) report("blue", blue, want.b);
				if (alpha !== want.a) report("alpha", alpha, want.a);
				if (status !== want.st) report("status", status, want.st);
			end
		end
	end

	// watchdog: cycles with neither a taken command nor a done word
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 5000) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	// defaults: not ready, type checks against a plain texture
	task automatic test_reset_defaults();
		send_cmd(face_cmd(OP_FACE, 0, 0, 0, 0));
		send_cmd(face_cmd(OP_2D, 65536, 65536, 0, 0));
		send_cmd(dir_cmd(1, 0, 0));
		store_byte(16'hFFFF, 8'hFF);
		store_byte(16'h0000, 8'h00);
	endtask

	task automatic test_plain_texture();
		set_texture(4, 3, 2, 4, 0, 96, 1);
		send_cmd(face_cmd(OP_FACE, 0, 0, 0, 0));
		send_cmd(face_cmd(OP_FACE, 65536, 65536, 65536, 0));
		send_cmd(face_cmd(OP_FACE, 32768, 32767, 98303, 0));
		send_cmd(face_cmd(OP_FACE, 131071, 0, 0, 0));      // past the end
		send_cmd(face_cmd(OP_FACE, 0, 0, 0, 7));           // bad face
		send_cmd(face_cmd(OP_2D, 65536, 0, 131071, 0));    // w ignored
		send_cmd(dir_cmd(0, 0, 5));                        // wrong type
		for (int cc = 1; cc <= 3; cc++) begin
			set_texture(4, 3, 2, cc, 0, 96, 1);
			send_cmd(face_cmd(OP_FACE, 65536, 0, 65536, 0));
		end
		set_texture(4, 3, 2, 0, 0, 96, 1);                 // bad channel count
		send_cmd(face_cmd(OP_FACE, 0, 0, 0, 0));
		set_texture(4, 3, 2, 4, 0, 0, 1);                  // empty store
		send_cmd(face_cmd(OP_2D, 0, 0, 0, 0));
	endtask

	task automatic test_cube_faces();
		set_texture(5, 5, 1, 3, 1, 450, 1);
		send_cmd(dir_cmd(100, 20, -30));
		send_cmd(dir_cmd(-100, 20, 30));
		send_cmd(dir_cmd(7, 9, -3));
		send_cmd(dir_cmd(7, -9, 3));
		send_cmd(dir_cmd(1, 2, 3));
		send_cmd(dir_cmd(-1, 2, -3));
		send_cmd(dir_cmd(4, -4, 4));                       // three-way tie
		send_cmd(dir_cmd(-4, 4, 0));                       // x/y tie
		send_cmd(dir_cmd(-32768, 32767, -32768));
		send_cmd(dir_cmd(0, 0, 0));                        // zero direction
		send_cmd(face_cmd(OP_FACE, 65536, 65536, 0, 5));
		send_cmd(face_cmd(OP_FACE, 0, 0, 0, 6));           // bad face
		send_cmd(face_cmd(OP_2D, 0, 0, 0, 0));             // wrong type
	endtask

	function automatic cmd_t random_cmd();
		cmd_t c;
		int pick;
		pick = $urandom_range(0, 9);
		c.op = pick < 2 ? OP_WRITE : (pick < 5 ? OP_FACE : (pick < 7 ? OP_2D : OP_CUBE));
		c.waddr = $urandom;
		c.wbyte = $urandom;
		c.u = $urandom_range(0, 7) == 0 ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
		c.v = $urandom_range(0, 7) == 0 ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
		c.w = $urandom_range(0, 7) == 0 ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
		c.face = $urandom_range(0, 7) == 0 ? $urandom_range(0, 7) : $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0) begin
			c.dx = $signed(16'($urandom_range(0, 4))) - 16'sd2;
			c.dy = $signed(16'($urandom_range(0, 4))) - 16'sd2;
			c.dz = $signed(16'($urandom_range(0, 4))) - 16'sd2;
		end else begin
			c.dx = $urandom;
			c.dy = $urandom;
			c.dz = $urandom;
		end
		return c;
	endfunction

	task automatic test_random_phase(input int ex, input int ey, input int ez, input int cc,
			input int kind, input int loaded, input int n);
		int burst;
		set_texture(ex, ey, ez, cc, kind, loaded, 1);
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				if ($urandom_range(0, 2) != 0)
					idle_cycles($urandom_range(1, 6));
			end
			burst--;
			send_cmd(random_cmd());
			if (i == n / 2)
				wait_drained();                            // let the pipe run dry
		end
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		start = 0;
		opcode = OP_WRITE;
		write_address = 0;
		write_byte = 0;
		coord_u = 0;
		coord_v = 0;
		coord_w = 0;
		face_select = 0;
		dir_x = 0;
		dir_y = 0;
		dir_z = 0;
		cfg_we = 0;
		cfg_index = REG_EXTENT_X;
		cfg_wdata = 0;
		mismatches = 0;
		m_ext_x = 1;
		m_ext_y = 1;
		m_ext_z = 1;
		m_chan = 4;
		m_kind = 0;
		m_loaded = 0;
		m_ready = 0;
		foreach (texel_written[i])
			texel_written[i] = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;

		test_reset_defaults();
		test_plain_texture();
		test_cube_faces();
		test_random_phase(8, 8, 4, 4, 0, 1024, 200);
		test_random_phase(256, 256, 1, 1, 0, 65536, 200);
		test_random_phase(1, 1, 1, 2, 0, 2, 150);
		test_random_phase(16, 16, 1, 3, 1, 4608, 250);
		test_random_phase(256, 256, 1, 1, 1, 131071, 200);
		test_random_phase(511, 0, 300, 4, 0, 70000, 150);
		test_random_phase(32, 8, 2, 4, 1, 20000, 250);
		test_random_phase(2, 2, 2, 7, 0, 64, 50);
		test_random_phase(3, 5, 7, 2, 0, 0, 50);
		wait_drained();

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/ntcs_pkg.sv
hw/rtl/ntcs_div.sv
hw/rtl/ntcs_front.sv
hw/rtl/ntcs_queue.sv
hw/rtl/ntcs_back.sv
hw/rtl/nearest_texel_cube_sampler_top.sv
tb/nearest_texel_cube_sampler_top_test.sv
